>>> rtl/ngup_pkg.sv
// Package for the nogood propagation block: sizes, op codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
package ngup_pkg;
    localparam int MAX_ATTRS = 64;
    localparam int MAX_RULES = 64;
    localparam int MAX_LITS  = 8;
    localparam int AW = $clog2(MAX_ATTRS);
    localparam int RW = $clog2(MAX_RULES);
    localparam int LW = (MAX_LITS > 1) ? $clog2(MAX_LITS) : 1;
    localparam int LENW = $clog2(MAX_LITS + 1);
    localparam int LITW = AW + 1;

    localparam logic [1:0] TV_UNKNOWN = 2'd0;
    localparam logic [1:0] TV_TRUE    = 2'd1;
    localparam logic [1:0] TV_FALSE   = 2'd2;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_LOAD  = 3'd2;
    localparam logic [2:0] OP_PROP  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_FIND  = 3'd5;

    localparam logic REG_ATTRS = 1'b0;
    localparam logic REG_RULES = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] attr_index;
        logic       truth_in;
        logic [5:0] rule_index;
        logic [2:0] lit_pos;
        logic       lit_negated;
        logic       lit_last;
    } in_item_t;

    typedef struct packed {
        logic       contradicted;
        logic [1:0] truth_out;
        logic       unknown_found;
        logic [5:0] unknown_index;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_RREAD, ST_FIND, ST_PR_RULE, ST_PR_LEN, ST_PR_LIT,
        ST_PR_ATTR, ST_PR_EVAL, ST_PR_FORCE, ST_PR_WRITE, ST_DONE
    } state_t;
endpackage

>>> rtl/ngup_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module ngup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/nogood_unit_propagation.sv
// Top level of the nogood propagation block: attribute, literal and length
// memories with a read-modify-write sequencer. Depends on ngup_pkg, ngup_ram.
`timescale 1ns / 1ps
// Clear and find step through the attributes at one attribute access a cycle.
// Propagate sweeps over the rules and their literals; sweeps repeat until one
// changes nothing or a contradiction is found. One item is in work at a time.
// Reset: synchronous active low; attributes start unknown through a clearing
// pass after reset, during which no item is taken.
module nogood_unit_propagation (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ngup_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ngup_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_data
);
    import ngup_pkg::*;

    state_t state_reg, state_next;
    out_item_t res_reg, res_next;
    logic out_v_reg, out_v_next;
    logic contra_reg, contra_next;
    logic boot_reg;
    logic [6:0] attrs_reg, rules_reg;
    logic [AW:0] cnt_reg, cnt_next;
    logic [RW:0] rule_reg, rule_next;
    logic [LW:0] i_reg, i_next, j_reg, j_next;
    logic [LENW-1:0] len_reg, len_next;
    logic others_reg, others_next, changed_reg, changed_next;
    logic [LITW-1:0] lit_i_reg, lit_i_next;
    logic [LITW-1:0] lit_j_reg, lit_j_next;
    logic [1:0] ival_reg, ival_next;

    // memories
    logic t_we; logic [AW-1:0] t_wa, t_ra; logic [1:0] t_wd, t_rd;
    logic l_we; logic [RW+LW-1:0] l_wa, l_ra; logic [LITW-1:0] l_wd, l_rd;
    logic n_we; logic [RW-1:0] n_wa, n_ra; logic [LENW-1:0] n_wd, n_rd;
    logic [MAX_RULES-1:0] len_vld_reg;

    ngup_ram #(.WIDTH(2), .DEPTH(MAX_ATTRS)) u_truth (.aclk, .we(t_we),
        .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
    ngup_ram #(.WIDTH(LITW), .DEPTH(MAX_RULES*MAX_LITS)) u_lits (.aclk, .we(l_we),
        .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    ngup_ram #(.WIDTH(LENW), .DEPTH(MAX_RULES)) u_lens (.aclk, .we(n_we),
        .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

    logic [RW-1:0] len_ra_reg;
    logic [LENW-1:0] len_eff;
    logic [AW:0] attr_lim;
    logic [RW:0] rule_lim;
    logic lit_holds;
    logic hit_contra;
    logic [LW:0] j_inc;

    assign len_eff = len_vld_reg[len_ra_reg] ? n_rd : '0;
    assign attr_lim = (attrs_reg > 7'(MAX_ATTRS)) ? (AW+1)'(MAX_ATTRS) : (AW+1)'(attrs_reg);
    assign rule_lim = (rules_reg > 7'(MAX_RULES)) ? (RW+1)'(MAX_RULES) : (RW+1)'(rules_reg);
    // literal in lit_j_reg evaluated against attribute data t_rd
    assign lit_holds = lit_j_reg[LITW-1] ? (t_rd == TV_FALSE) : (t_rd == TV_TRUE);
    assign hit_contra = others_reg &&
        (lit_i_reg[LITW-1] ? (ival_reg == TV_FALSE) : (ival_reg == TV_TRUE));
    assign j_inc = j_reg + 1'b1;

    assign s_ready = (state_reg == ST_IDLE) && !out_v_reg;
    assign cfg_ready = 1'b1;
    assign m_valid = out_v_reg;
    assign m_data = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            out_v_reg <= 1'b0;
            contra_reg <= 1'b0;
            boot_reg <= 1'b1;
            attrs_reg <= 7'd64;
            rules_reg <= 7'd0;
            cnt_reg <= '0;
            len_vld_reg <= '0;
        end else begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
            contra_reg <= contra_next;
            boot_reg <= boot_reg && (state_reg == ST_CLR);
            cnt_reg <= cnt_next;
            if (cfg_valid) begin
                if (cfg_index == REG_ATTRS) attrs_reg <= cfg_data;
                else rules_reg <= cfg_data;
            end
            if (n_we) len_vld_reg[n_wa] <= 1'b1;
        end
        res_reg <= res_next;
        rule_reg <= rule_next;
        i_reg <= i_next;
        j_reg <= j_next;
        len_reg <= len_next;
        others_reg <= others_next;
        changed_reg <= changed_next;
        lit_i_reg <= lit_i_next;
        lit_j_reg <= lit_j_next;
        ival_reg <= ival_next;
        len_ra_reg <= n_ra;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready) begin
                case (s_data.op)
                    OP_CLEAR: state_next = ST_CLR;
                    OP_READ:  state_next = ST_RREAD;
                    OP_FIND:  state_next = ST_FIND;
                    OP_PROP:  state_next = ST_PR_RULE;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_CLR: if (cnt_reg == (AW+1)'(MAX_ATTRS - 1)) begin
                state_next = boot_reg ? ST_IDLE : ST_DONE;
            end
            ST_RREAD: state_next = ST_DONE;
            ST_FIND: begin
                if (cnt_reg > '0 && (t_rd == TV_UNKNOWN || cnt_reg >= attr_lim))
                    state_next = ST_DONE;
                else if (cnt_reg >= attr_lim) state_next = ST_DONE;
            end
            ST_PR_RULE: begin
                if (rule_reg >= rule_lim)
                    state_next = changed_reg ? ST_PR_RULE : ST_DONE;
                else state_next = ST_PR_LEN;
            end
            ST_PR_LEN: state_next = ST_PR_LIT;
            ST_PR_LIT: begin
                if ((LENW+1)'(i_reg) >= (LENW+1)'(len_reg)) state_next = ST_PR_RULE;
                else state_next = ST_PR_ATTR;
            end
            ST_PR_ATTR: state_next = ST_PR_EVAL;
            ST_PR_EVAL: begin
                if ((LENW+1)'(j_reg) >= (LENW+1)'(len_reg)) state_next = ST_PR_FORCE;
                else state_next = ST_PR_EVAL;
            end
            ST_PR_FORCE: state_next = ST_PR_WRITE;
            ST_PR_WRITE: begin
                if (hit_contra) state_next = ST_DONE;
                else state_next = ST_PR_LIT;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_v_next = out_v_reg && !m_ready;
        res_next = res_reg;
        contra_next = contra_reg;
        cnt_next = cnt_reg;
        rule_next = rule_reg;
        i_next = i_reg;
        j_next = j_reg;
        len_next = len_reg;
        others_next = others_reg;
        changed_next = changed_reg;
        lit_i_next = lit_i_reg;
        lit_j_next = lit_j_reg;
        ival_next = ival_reg;
        t_we = 1'b0; t_wa = '0; t_wd = TV_UNKNOWN; t_ra = '0;
        l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
        n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = rule_reg[RW-1:0];
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                rule_next = '0;
                changed_next = 1'b0;
                t_ra = s_data.attr_index[AW-1:0];
                if (s_valid && s_ready) begin
                    res_next = '0;
                    if (s_data.op == OP_CLEAR) contra_next = 1'b0;
                    if (s_data.op == OP_SET) begin
                        t_we = 1'b1;
                        t_wa = s_data.attr_index[AW-1:0];
                        t_wd = s_data.truth_in ? TV_TRUE : TV_FALSE;
                    end
                    if (s_data.op == OP_LOAD) begin
                        l_we = 1'b1;
                        l_wa = {s_data.rule_index[RW-1:0], s_data.lit_pos[LW-1:0]};
                        l_wd = {s_data.lit_negated, s_data.attr_index[AW-1:0]};
                        n_we = s_data.lit_last;
                        n_wa = s_data.rule_index[RW-1:0];
                        n_wd = LENW'(s_data.lit_pos) + LENW'(1);
                    end
                end
            end
            ST_CLR: begin
                t_we = 1'b1;
                t_wa = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + 1'b1;
            end
            ST_RREAD: res_next.truth_out = t_rd;
            ST_FIND: begin
                t_ra = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg > '0 && t_rd == TV_UNKNOWN && cnt_reg <= attr_lim) begin
                    res_next.unknown_found = 1'b1;
                    res_next.unknown_index = 6'(cnt_reg - 1'b1);
                end
            end
            ST_PR_RULE: begin
                n_ra = rule_reg[RW-1:0];
                if (rule_reg >= rule_lim) begin
                    rule_next = '0;
                    changed_next = 1'b0;
                end
            end
            ST_PR_LEN: begin
                len_next = (len_eff > LENW'(MAX_LITS)) ? LENW'(MAX_LITS) : len_eff;
                i_next = '0;
            end
            ST_PR_LIT: begin
                l_ra = {rule_reg[RW-1:0], i_reg[LW-1:0]};
                j_next = '0;
                others_next = 1'b1;
                if ((LENW+1)'(i_reg) >= (LENW+1)'(len_reg)) rule_next = rule_reg + 1'b1;
            end
            ST_PR_ATTR: begin
                lit_i_next = l_rd;
                t_ra = l_rd[AW-1:0];
                l_ra = {rule_reg[RW-1:0], j_reg[LW-1:0]};
            end
            ST_PR_EVAL: begin
                // l_rd holds literal j; t_rd holds literal j-1's attribute,
                // or literal i's attribute on the first visit
                if (j_reg == '0) ival_next = t_rd;
                else if ((j_reg - 1'b1) != i_reg && !lit_holds) others_next = 1'b0;
                lit_j_next = l_rd;
                t_ra = l_rd[AW-1:0];
                l_ra = {rule_reg[RW-1:0], j_inc[LW-1:0]};
                j_next = j_inc;
                if ((LENW+1)'(j_reg) >= (LENW+1)'(len_reg)) j_next = j_reg;
            end
            ST_PR_FORCE: ;
            ST_PR_WRITE: begin
                i_next = i_reg + 1'b1;
                if (hit_contra) contra_next = 1'b1;
                else if (others_reg && ival_reg == TV_UNKNOWN) begin
                    t_we = 1'b1;
                    t_wa = lit_i_reg[AW-1:0];
                    t_wd = lit_i_reg[LITW-1] ? TV_TRUE : TV_FALSE;
                    changed_next = 1'b1;
                end
            end
            ST_DONE: begin
                out_v_next = 1'b1;
                res_next.contradicted = contra_reg;
            end
            default: ;
        endcase
    end
endmodule

>>> rtl/ngup_checker.sv
// Port-level checker for nogood_unit_propagation, bound to the top level.
// Depends on ngup_pkg.
`timescale 1ns / 1ps
module ngup_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input ngup_pkg::out_item_t m_data
);
    import ngup_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken during work");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
    a_truth_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.truth_out != 2'd3)
        else $error("invalid truth code");
endmodule

bind nogood_unit_propagation ngup_checker u_ngup_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data);
